// ----- rtl/rlcd_pkg.sv -----
// Shared types and constants for the RGB LED chain driver.
`default_nettype none
package rlcd_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_SHOW  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_PIXEL_COUNT = 3'd0;
	localparam logic [2:0] REG_BRIGHTNESS  = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [2:0] REG_ONE_HIGH    = 3'd3;
	localparam logic [2:0] REG_BIT_PERIOD  = 3'd4;
	localparam logic [2:0] REG_LATCH_GAP   = 3'd5;

	localparam int CFG_W = 17;

	// Reset values of the configuration registers.
	localparam logic [6:0]  RST_PIXEL_COUNT = 7'd0;
	localparam logic [7:0]  RST_BRIGHTNESS  = 8'd255;
	localparam logic [11:0] RST_ZERO_HIGH   = 12'd96;
	localparam logic [11:0] RST_ONE_HIGH    = 12'd192;
	localparam logic [11:0] RST_BIT_PERIOD  = 12'd300;
	localparam logic [16:0] RST_LATCH_GAP   = 17'd72000;

	// The idle counter saturates here.
	localparam logic [16:0] GAP_MAX = 17'h1FFFF;

	// One classified command waiting for the line engine.
	typedef struct packed {
		logic [1:0]  mode;
		logic        in_range;
		logic [5:0]  idx;
		logic [23:0] grb;
	} rlcd_item_t;

	// Bit timing settings used by the line engine.
	typedef struct packed {
		logic [11:0] zero_high;
		logic [11:0] one_high;
		logic [11:0] period;
		logic [16:0] gap;
	} rlcd_timing_t;

endpackage
`default_nettype wire

// ----- rtl/rlcd_front.sv -----
// Front end: decodes an incoming beat, checks the pixel index and scales the colors.
`default_nettype none
module rlcd_front #(
	parameter int MAX_PIXELS = 64,
	parameter int CW = $clog2(MAX_PIXELS + 1)
) (
	input  wire logic [1:0]          mode,
	input  wire logic [5:0]          pixel_index,
	input  wire logic [7:0]          red,
	input  wire logic [7:0]          green,
	input  wire logic [7:0]          blue,
	input  wire logic [CW-1:0]       count,
	input  wire logic [7:0]          brightness,
	output rlcd_pkg::rlcd_item_t     item
);
	import rlcd_pkg::*;

	localparam int CMPW = (CW > 6) ? CW : 6;

	// Scale one color by (brightness + 1) / 256.
	function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] b);
		logic [16:0] prod;
		prod = {9'd0, c} * {8'd0, ({1'b0, b} + 9'd1)};
		return prod[15:8];
	endfunction

	// Build the queue entry; colors are stored green, red, blue from the low byte up.
	always_comb begin
		item.mode     = mode;
		item.idx      = pixel_index;
		item.in_range = CMPW'(pixel_index) < CMPW'(count);
		item.grb      = {scale(blue, brightness), scale(red, brightness),
		                 scale(green, brightness)};
	end

endmodule
`default_nettype wire

// ----- rtl/rlcd_queue.sv -----
// Two-entry queue between the front end and the line engine.
`default_nettype none
module rlcd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push_valid,
	output logic                      push_ready,
	input  wire rlcd_pkg::rlcd_item_t push_item,
	output logic                      pop_valid,
	input  wire logic                 pop,
	output rlcd_pkg::rlcd_item_t      pop_item
);
	import rlcd_pkg::*;

	rlcd_item_t  ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rlcd_back.sv -----
// Back end: executes commands, holds the frame store and drives the serial line.
`default_nettype none
module rlcd_back #(
	parameter int MAX_PIXELS = 64,
	parameter int CW = $clog2(MAX_PIXELS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [CW-1:0]        count,
	input  wire rlcd_pkg::rlcd_timing_t tcfg,
	input  wire logic                 q_valid,
	input  wire rlcd_pkg::rlcd_item_t q_item,
	output logic                      q_pop,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [7:0]                m_axis_tdata  // [0] line, [1] busy_res, [2] rejected
);
	import rlcd_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	// Frame store: one row of green, red, blue per pixel.
	logic [23:0]           mem [MAX_PIXELS];
	logic [MAX_PIXELS-1:0] valid_q;
	logic [23:0]           mem_rd_q;
	logic [23:0]           fwd_row_q;
	logic                  fwd_q;
	logic                  zero_q;

	// Line engine state.
	logic                  sending_q;
	logic                  pending_q;
	logic [16:0]           gap_q;
	logic [11:0]           timer_q;
	logic [2:0]            bitpos_q;
	logic [1:0]            sub_q;
	logic [CW-1:0]         ptr_q;

	// Output register.
	logic                  out_valid_q;
	logic                  line_q;
	logic                  busy_q;
	logic                  rej_q;

	logic                  fire;
	logic                  rej;
	logic                  set_ok;
	logic                  clr;
	logic                  show_ok;
	logic                  pending_c;
	logic                  busy;
	logic                  start;
	logic                  sending_c;
	logic [11:0]           timer_c;
	logic [2:0]            bitpos_c;
	logic [1:0]            sub_c;
	logic [CW-1:0]         ptr_c;
	logic [CW-1:0]         ptr_adv;
	logic [23:0]           row_eff;
	logic [7:0]            cur_byte;
	logic [11:0]           high;
	logic [12:0]           timer_inc;
	logic                  line;
	logic                  sending_n;
	logic                  pending_n;
	logic [16:0]           gap_n;
	logic [11:0]           timer_n;
	logic [2:0]            bitpos_n;
	logic [1:0]            sub_n;
	logic [CW-1:0]         ptr_n;
	logic [CW-1:0]         rd_ptr;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [MAX_PIXELS-1:0] valid_n;

	assign fire    = q_valid && (!out_valid_q || m_axis_tready);
	assign q_pop   = fire;
	assign wr_addr = AW'(q_item.idx);

	// Row of the pixel being sent, with writes of the previous beat folded in.
	assign row_eff = fwd_q ? fwd_row_q : (zero_q ? 24'd0 : mem_rd_q);

	// Command handling, then one tick of the line engine.
	always_comb begin
		rej       = (q_item.mode != MODE_TICK) && (sending_q || pending_q);
		set_ok    = fire && !rej && (q_item.mode == MODE_SET) && q_item.in_range;
		clr       = fire && !rej && (q_item.mode == MODE_CLEAR);
		show_ok   = !rej && (q_item.mode == MODE_SHOW) && (count != '0);
		pending_c = pending_q || show_ok;
		busy      = sending_q || pending_c;
		start     = pending_c && (gap_q >= tcfg.gap);
		sending_c = sending_q || start;
		timer_c   = start ? 12'd0 : timer_q;
		bitpos_c  = start ? 3'd7 : bitpos_q;
		sub_c     = start ? 2'd0 : sub_q;
		ptr_c     = start ? '0 : ptr_q;

		case (sub_c)
			2'd0:    cur_byte = row_eff[7:0];
			2'd1:    cur_byte = row_eff[15:8];
			default: cur_byte = row_eff[23:16];
		endcase
		high      = cur_byte[bitpos_c] ? tcfg.one_high : tcfg.zero_high;
		timer_inc = {1'b0, timer_c} + 13'd1;
		ptr_adv   = (sub_c == 2'd2) ? (ptr_c + CW'(1)) : ptr_c;

		line      = 1'b0;
		sending_n = sending_c;
		pending_n = pending_c && !start;
		gap_n     = gap_q;
		timer_n   = timer_c;
		bitpos_n  = bitpos_c;
		sub_n     = sub_c;
		ptr_n     = ptr_c;

		if (sending_c) begin
			line    = (timer_c < high);
			timer_n = timer_inc[11:0];
			if (timer_inc >= {1'b0, tcfg.period}) begin
				timer_n = 12'd0;
				if (bitpos_c == 3'd0) begin
					bitpos_n = 3'd7;
					if (ptr_adv >= count) begin
						// Last byte of the frame is out.
						sending_n = 1'b0;
						ptr_n     = '0;
						sub_n     = 2'd0;
						gap_n     = 17'd0;
					end else begin
						ptr_n = ptr_adv;
						sub_n = (sub_c == 2'd2) ? 2'd0 : (sub_c + 2'd1);
					end
				end else begin
					bitpos_n = bitpos_c - 3'd1;
				end
			end
		end else if (gap_q != GAP_MAX) begin
			gap_n = gap_q + 17'd1;
		end
	end

	// Next valid bits: clear drops the active rows, a pixel write marks its row.
	always_comb begin
		valid_n = valid_q;
		if (clr) begin
			for (int r = 0; r < MAX_PIXELS; r++) begin
				if (32'(r) < 32'(count)) begin
					valid_n[r] = 1'b0;
				end
			end
		end
		if (set_ok) begin
			valid_n[wr_addr] = 1'b1;
		end
	end

	assign rd_ptr  = fire ? ptr_n : ptr_q;
	assign rd_addr = rd_ptr[AW-1:0];

	// Frame store write and prefetch of the row the next beat will send.
	always_ff @(posedge clk) begin
		if (set_ok) begin
			mem[wr_addr] <= q_item.grb;
		end
		mem_rd_q  <= mem[rd_addr];
		fwd_row_q <= q_item.grb;
		line_q    <= fire ? line : line_q;
		busy_q    <= fire ? busy : busy_q;
		rej_q     <= fire ? rej : rej_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_q       <= 1'b0;
			zero_q      <= 1'b1;
			sending_q   <= 1'b0;
			pending_q   <= 1'b0;
			gap_q       <= 17'd0;
			timer_q     <= 12'd0;
			bitpos_q    <= 3'd7;
			sub_q       <= 2'd0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_q <= valid_n;
			fwd_q   <= set_ok && (wr_addr == rd_addr);
			zero_q  <= !valid_n[rd_addr];
			if (fire) begin
				sending_q <= sending_n;
				pending_q <= pending_n;
				gap_q     <= gap_n;
				timer_q   <= timer_n;
				bitpos_q  <= bitpos_n;
				sub_q     <= sub_n;
				ptr_q     <= ptr_n;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, rej_q, busy_q, line_q};

	// A frame is never waiting and being sent at once.
	assert property (@(posedge clk) disable iff (!arst_n) !(sending_q && pending_q))
		else $error("show pending while a frame is being sent");

	// A refused command always reports busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rej_q) |-> busy_q)
		else $error("rejected result without busy");

	// The line only goes high while a frame is out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && line_q) |-> busy_q)
		else $error("line high outside a frame");

	// The end of a frame restarts the idle count.
	assert property (@(posedge clk) disable iff (!arst_n) $fell(sending_q) |-> (gap_q == 17'd0))
		else $error("idle count not restarted at end of frame");

endmodule
`default_nettype wire

// ----- rtl/rgb_led_chain_driver.sv -----
// Top level of the RGB LED chain driver: configuration registers, front end, queue, line engine.
// A result passes through the queue and the output register after its beat is accepted.
// Throughput: one beat per cycle without output back-pressure; each beat is a line engine tick.
// The line engine in the back end advances exactly one tick per beat and paces the block.
// Reset is asynchronous and active low; it restores all configuration defaults.
// The frame store reads as zero after reset through per-pixel valid bits; no clearing pass.
`default_nettype none
module rgb_led_chain_driver #(
	parameter int MAX_PIXELS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [31:0]                  s_axis_tdata,  // [5:0] pixel_index, [13:6] red,
	                                                         // [21:14] green, [29:22] blue
	input  wire logic [1:0]                   s_axis_tuser,  // [1:0] mode
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [0] line, [1] busy_res,
	                                                         // [2] rejected
	input  wire logic                         cfg_we,
	input  wire logic [2:0]                   cfg_addr,
	input  wire logic [rlcd_pkg::CFG_W-1:0]   cfg_wdata
);
	import rlcd_pkg::*;

	localparam int CW = $clog2(MAX_PIXELS + 1);

	logic [6:0]   pixel_count_q;
	logic [7:0]   brightness_q;
	logic [11:0]  zero_high_q;
	logic [11:0]  one_high_q;
	logic [11:0]  period_q;
	logic [16:0]  gap_len_q;
	logic [CW-1:0] count;
	rlcd_timing_t tcfg;
	rlcd_item_t   front_item;
	rlcd_item_t   q_item;
	logic         q_valid;
	logic         q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= RST_PIXEL_COUNT;
			brightness_q  <= RST_BRIGHTNESS;
			zero_high_q   <= RST_ZERO_HIGH;
			one_high_q    <= RST_ONE_HIGH;
			period_q      <= RST_BIT_PERIOD;
			gap_len_q     <= RST_LATCH_GAP;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PIXEL_COUNT: pixel_count_q <= cfg_wdata[6:0];
				REG_BRIGHTNESS:  brightness_q  <= cfg_wdata[7:0];
				REG_ZERO_HIGH:   zero_high_q   <= cfg_wdata[11:0];
				REG_ONE_HIGH:    one_high_q    <= cfg_wdata[11:0];
				REG_BIT_PERIOD:  period_q      <= cfg_wdata[11:0];
				REG_LATCH_GAP:   gap_len_q     <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	// Active pixel count, capped at the store size.
	assign count = (32'(pixel_count_q) > 32'(MAX_PIXELS)) ? CW'(MAX_PIXELS)
	                                                      : CW'(pixel_count_q);

	assign tcfg.zero_high = zero_high_q;
	assign tcfg.one_high  = one_high_q;
	assign tcfg.period    = period_q;
	assign tcfg.gap       = gap_len_q;

	rlcd_front #(
		.MAX_PIXELS(MAX_PIXELS),
		.CW(CW)
	) u_front (
		.mode(s_axis_tuser),
		.pixel_index(s_axis_tdata[5:0]),
		.red(s_axis_tdata[13:6]),
		.green(s_axis_tdata[21:14]),
		.blue(s_axis_tdata[29:22]),
		.count(count),
		.brightness(brightness_q),
		.item(front_item)
	);

	rlcd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(s_axis_tvalid),
		.push_ready(s_axis_tready),
		.push_item(front_item),
		.pop_valid(q_valid),
		.pop(q_pop),
		.pop_item(q_item)
	);

	rlcd_back #(
		.MAX_PIXELS(MAX_PIXELS),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.count(count),
		.tcfg(tcfg),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- tb/sv/rgb_led_chain_driver_tb.sv -----
// Self-checking testbench for the RGB LED chain driver: tick stimulus, line prediction, checks.
`timescale 1ns / 1ps
module rgb_led_chain_driver_tb;
	import rlcd_pkg::*;

	localparam int MAXP        = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	// One input beat: a tick with an optional command.
	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} led_beat_t;

	// One output beat: line level and status for one tick.
	typedef struct packed {
		logic line;
		logic busy;
		logic rejected;
	} line_level_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [31:0]          in_tdata  = '0;
	logic [1:0]           in_tuser  = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [2:0]           cfg_addr  = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	wire logic            s_axis_tready;
	wire logic            m_axis_tvalid;
	wire logic [7:0]      m_axis_tdata;

	rgb_led_chain_driver #(.MAX_PIXELS(MAXP)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (in_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (in_tdata),
		.s_axis_tuser  (in_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (out_ready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the configuration registers.
	logic [6:0]  cfg_count;
	logic [7:0]  cfg_bright;
	logic [11:0] cfg_zero;
	logic [11:0] cfg_one;
	logic [11:0] cfg_period;
	logic [16:0] cfg_gap;

	// Shadow copy of the frame store and the line engine.
	logic [7:0]  frame_bytes [0:MAXP*3-1];
	int unsigned byte_pos;
	int unsigned bit_pos;
	int unsigned bit_tick;
	int unsigned idle_ticks;
	bit          sending;
	bit          show_wait;

	led_beat_t   beats_to_send [$];
	line_level_t expected_levels [$];

	int n_sent;
	int n_accepted;
	int n_checked;
	int n_errors;
	int n_refused;
	int n_frames;
	int n_settings;

	function automatic void reset_chain();
		cfg_count  = RST_PIXEL_COUNT;
		cfg_bright = RST_BRIGHTNESS;
		cfg_zero   = RST_ZERO_HIGH;
		cfg_one    = RST_ONE_HIGH;
		cfg_period = RST_BIT_PERIOD;
		cfg_gap    = RST_LATCH_GAP;
		for (int i = 0; i < MAXP * 3; i++)
			frame_bytes[i] = 8'd0;
		byte_pos   = 0;
		bit_pos    = 7;
		bit_tick   = 0;
		idle_ticks = 0;
		sending    = 1'b0;
		show_wait  = 1'b0;
	endfunction

	function automatic logic [7:0] scale_level(input logic [7:0] c);
		int unsigned p;
		p = int'(c) * (int'(cfg_bright) + 1);
		return 8'(p >> 8);
	endfunction

	// Apply one beat to the shadow state and return the level the block should emit.
	function automatic line_level_t tick_chain(input led_beat_t b);
		line_level_t o;
		int unsigned cnt;
		int unsigned base;
		int unsigned high;
		logic [7:0]  cur_byte;
		o   = '0;
		cnt = (cfg_count > MAXP) ? MAXP : cfg_count;

		// Command first; anything but a plain tick is refused while busy.
		if (b.mode != MODE_TICK && (sending || show_wait)) begin
			o.rejected = 1'b1;
			n_refused++;
		end else if (b.mode == MODE_SET) begin
			if (b.idx < cnt) begin
				base = int'(b.idx) * 3;
				frame_bytes[base]     = scale_level(b.green);
				frame_bytes[base + 1] = scale_level(b.red);
				frame_bytes[base + 2] = scale_level(b.blue);
			end
		end else if (b.mode == MODE_CLEAR) begin
			for (int i = 0; i < cnt * 3; i++)
				frame_bytes[i] = 8'd0;
		end else if (b.mode == MODE_SHOW) begin
			if (cnt != 0)
				show_wait = 1'b1;
		end

		o.busy = sending || show_wait;

		// A pending show starts once the latch gap has passed.
		if (show_wait && idle_ticks >= cfg_gap) begin
			show_wait = 1'b0;
			sending   = 1'b1;
			byte_pos  = 0;
			bit_pos   = 7;
			bit_tick  = 0;
			n_frames++;
		end

		// Line engine: one tick of the current bit cell, or one more idle tick.
		if (sending) begin
			cur_byte = (byte_pos < MAXP * 3) ? frame_bytes[byte_pos] : 8'd0;
			high     = cur_byte[bit_pos & 7] ? cfg_one : cfg_zero;
			o.line   = (bit_tick < high);
			bit_tick++;
			if (bit_tick >= cfg_period) begin
				bit_tick = 0;
				if (bit_pos == 0) begin
					bit_pos = 7;
					byte_pos++;
					if (byte_pos >= cnt * 3) begin
						sending    = 1'b0;
						byte_pos   = 0;
						idle_ticks = 0;
					end
				end else begin
					bit_pos--;
				end
			end
		end else if (idle_ticks < GAP_MAX) begin
			idle_ticks++;
		end
		return o;
	endfunction

	// Sender: bursts of beats from the pending queue, separated by random gaps.
	led_beat_t on_bus;
	int        burst_left = 0;
	int        idle_left  = 0;

	always @(posedge clk) begin : sender
		logic v;
		if (arst_n) begin
			v = in_valid;
			if (in_valid && s_axis_tready) begin
				expected_levels.push_back(tick_chain(on_bus));
				n_accepted++;
				v = 1'b0;
			end
			if (!v) begin
				if (idle_left != 0) begin
					idle_left--;
				end else if (beats_to_send.size() != 0) begin
					on_bus = beats_to_send.pop_front();
					v      = 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 48);
					burst_left--;
					if (burst_left == 0)
						idle_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12) : 0;
				end
			end
			in_valid <= v;
			in_tdata <= {2'b00, on_bus.blue, on_bus.green, on_bus.red, on_bus.idx};
			in_tuser <= on_bus.mode;
		end
	end

	// Receiver: checks each output beat and stalls on a changing pattern.
	int rx_cycle  = 0;
	int hold_left = 0;
	bit held      = 1'b0;

	always @(posedge clk) begin : receiver
		line_level_t got;
		line_level_t want;
		logic        r;
		if (arst_n) begin
			rx_cycle++;
			if (m_axis_tvalid && out_ready) begin
				got.line     = m_axis_tdata[0];
				got.busy     = m_axis_tdata[1];
				got.rejected = m_axis_tdata[2];
				if (expected_levels.size() == 0) begin
					$error("output beat with no expected result pending");
					n_errors++;
				end else begin
					want = expected_levels.pop_front();
					if (got.line !== want.line) begin
						$error("line: expected %0d, got %0d", want.line, got.line);
						n_errors++;
					end
					if (got.busy !== want.busy) begin
						$error("busy_res: expected %0d, got %0d", want.busy, got.busy);
						n_errors++;
					end
					if (got.rejected !== want.rejected) begin
						$error("rejected: expected %0d, got %0d", want.rejected,
							got.rejected);
						n_errors++;
					end
				end
				n_checked++;
			end

			// One long hold-off while the sender keeps offering, then rotating patterns.
			if (hold_left != 0) begin
				hold_left--;
				r = 1'b0;
			end else if (!held && n_checked >= 500 && in_valid) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				r         = 1'b0;
			end else begin
				case ((rx_cycle >> 7) % 4)
					0: r = 1'b1;
					1: r = ($urandom_range(0, 3) != 0);
					2: r = (rx_cycle % 5 != 0);
					default: r = ($urandom_range(0, 1) != 0);
				endcase
			end
			out_ready <= r;
		end
	end

	// Watchdog on cycles without any handshake or register write.
	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && s_axis_tready) || (m_axis_tvalid && out_ready) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic void queue_beat(input logic [1:0] mode, input logic [5:0] idx,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		beats_to_send.push_back('{mode: mode, idx: idx, red: red, green: green, blue: blue});
		n_sent++;
	endfunction

	function automatic void queue_ticks(input int n);
		for (int i = 0; i < n; i++)
			queue_beat(MODE_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endfunction

	function automatic logic [7:0] rand_level();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 15)
			return 8'd0;
		if (k < 30)
			return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [11:0] rand_high_ticks();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return 12'($urandom_range(0, 5));
		if (k < 85)
			return 12'($urandom_range(0, 4095));
		return 12'd4095;
	endfunction

	task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		case (addr)
			REG_PIXEL_COUNT: cfg_count  = value[6:0];
			REG_BRIGHTNESS:  cfg_bright = value[7:0];
			REG_ZERO_HIGH:   cfg_zero   = value[11:0];
			REG_ONE_HIGH:    cfg_one    = value[11:0];
			REG_BIT_PERIOD:  cfg_period = value[11:0];
			REG_LATCH_GAP:   cfg_gap    = value[16:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input int unsigned cnt, input int unsigned bright,
			input int unsigned zero_hi, input int unsigned one_hi, input int unsigned period,
			input int unsigned gap);
		write_reg(REG_PIXEL_COUNT, CFG_W'(cnt));
		write_reg(REG_BRIGHTNESS, CFG_W'(bright));
		write_reg(REG_ZERO_HIGH, CFG_W'(zero_hi));
		write_reg(REG_ONE_HIGH, CFG_W'(one_hi));
		write_reg(REG_BIT_PERIOD, CFG_W'(period));
		write_reg(REG_LATCH_GAP, CFG_W'(gap));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_sent || expected_levels.size() != 0)
			@(posedge clk);
	endtask

	// Random traffic: mostly set/show sequences followed by up to 150 ticks to send the frame.
	function automatic void queue_traffic(input int target);
		int unsigned cnt;
		int unsigned per;
		int unsigned est;
		int unsigned k;
		int          n;
		cnt = (cfg_count > MAXP) ? MAXP : cfg_count;
		per = (cfg_period < 1) ? 1 : cfg_period;
		n   = 0;
		while (n < target) begin
			if ($urandom_range(0, 99) < 15) begin
				for (int i = 0; i < 8; i++)
					queue_beat(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
						rand_level(), rand_level(), rand_level());
				n += 8;
			end else begin
				k = $urandom_range(0, 4);
				for (int i = 0; i < k; i++)
					queue_beat(MODE_SET,
						6'((cnt != 0 && $urandom_range(0, 4) != 0) ?
							$urandom_range(0, cnt - 1) : $urandom_range(0, 63)),
						rand_level(), rand_level(), rand_level());
				n += k;
				if ($urandom_range(0, 4) == 0) begin
					queue_beat(MODE_CLEAR, 6'($urandom_range(0, 63)), rand_level(),
						rand_level(), rand_level());
					n++;
				end
				queue_beat(MODE_SHOW, 6'($urandom_range(0, 63)), rand_level(), rand_level(),
					rand_level());
				n++;
				est = cnt * 24 * per + cfg_gap + 2;
				if (est > 150)
					est = 150;
				for (int i = 0; i < est; i++) begin
					if ($urandom_range(0, 9) == 0)
						queue_beat(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
							rand_level(), rand_level(), rand_level());
					else
						queue_ticks(1);
				end
				n += est;
			end
		end
	endfunction

	initial begin
		int unsigned k;
		int unsigned cnt;
		int unsigned bright;
		int unsigned period;
		int unsigned gap;
		reset_chain();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, empty chain: set is out of range, show does nothing.
		queue_beat(MODE_SET, 6'd0, 8'd255, 8'd255, 8'd255);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_beat(MODE_CLEAR, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_beat(MODE_SET, 6'd63, 8'd255, 8'd0, 8'd255);
		queue_ticks(1);
		wait_drained();

		// One pixel, short cells: in-range and out-of-range sets, commands while busy.
		load_settings(1, 255, 1, 3, 2, 5);
		queue_beat(MODE_SET, 6'd0, 8'd255, 8'd0, 8'd255);
		queue_beat(MODE_SET, 6'd1, 8'd17, 8'd34, 8'd51);
		queue_beat(MODE_SET, 6'd63, 8'd255, 8'd255, 8'd255);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_beat(MODE_SET, 6'd0, 8'd1, 8'd2, 8'd3);
		queue_beat(MODE_CLEAR, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_ticks(50);
		queue_beat(MODE_CLEAR, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_ticks(60);
		wait_drained();

		// Zero high time, high time longer than the cell, one-tick cells.
		load_settings(2, 127, 0, 4095, 1, 0);
		queue_beat(MODE_SET, 6'd0, 8'd255, 8'd255, 8'd255);
		queue_beat(MODE_SET, 6'd1, 8'h80, 8'h01, 8'hfe);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_ticks(55);
		wait_drained();

		// Oversized count acts as the full chain; zero period, inverted high times.
		load_settings(127, 0, 4095, 0, 0, 3);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_ticks(40);
		wait_drained();

		// Shrink the chain mid-frame, then a show with the latch gap at its longest.
		load_settings(1, 255, 2, 5, 7, 131071);
		queue_ticks(10);
		queue_beat(MODE_SHOW, 6'd0, 8'd0, 8'd0, 8'd0);
		queue_ticks(20);
		queue_beat(MODE_SET, 6'd0, 8'd9, 8'd9, 8'd9);
		queue_ticks(3);

		// Random settings, each followed by a stretch of random traffic.
		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			k = $urandom_range(0, 99);
			if (k < 70)
				cnt = $urandom_range(1, 3);
			else if (k < 80)
				cnt = 0;
			else if (k < 90)
				cnt = $urandom_range(4, 8);
			else
				cnt = $urandom_range(64, 127);
			k = $urandom_range(0, 99);
			bright = (k < 20) ? 0 : (k < 40) ? 255 : $urandom_range(0, 255);
			k = $urandom_range(0, 99);
			period = (k < 75) ? $urandom_range(0, 6) : (k < 90) ? $urandom_range(7, 4095) : 4095;
			k = $urandom_range(0, 99);
			gap = (k < 70) ? $urandom_range(0, 20) : (k < 90) ? $urandom_range(0, 131071) : 131071;
			load_settings(cnt, bright, rand_high_ticks(), rand_high_ticks(), period, gap);
			queue_traffic(115);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d input beats and %0d output beats over %0d register settings;",
			n_accepted, n_checked, n_settings);
		$display("%0d frames started and %0d commands refused while busy.", n_frames, n_refused);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/rlcd_pkg.sv
rtl/rlcd_front.sv
rtl/rlcd_queue.sv
rtl/rlcd_back.sv
rtl/rgb_led_chain_driver.sv
tb/sv/rgb_led_chain_driver_tb.sv
